[rtl/ppt_pkg.sv]
package ppt_pkg;

    // mode codes on the input tuser
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_TEST   = 2'd2;

    // command kinds handed from the front end to the executor
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_CLEAR  = 2'd0;
    localparam kind_t KIND_APPEND = 2'd1;
    localparam kind_t KIND_TEST   = 2'd2;
    localparam kind_t KIND_NOP    = 2'd3;

    localparam int COORD_W = 32;

    // coordinates already sign-extended from the active coordinate width
    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } cmd_t;

endpackage

[rtl/ppt_ram.sv]
module ppt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ppt_fifo.sv]
module ppt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign dout      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[rtl/ppt_front.sv]
module ppt_front #(
    parameter int COORD_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    in_mode,
    input  logic [63:0]   in_data,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output ppt_pkg::cmd_t cmd
);

    import ppt_pkg::*;

    logic  hold_valid_reg, hold_valid_next;
    cmd_t  hold_reg, hold_next;
    logic  accept;
    logic signed [COORD_BITS-1:0] raw_x, raw_y;

    assign in_ready  = !hold_valid_reg || cmd_ready;
    assign accept    = in_valid && in_ready;
    assign cmd_valid = hold_valid_reg;
    assign cmd       = hold_reg;

    assign raw_x = in_data[COORD_BITS-1:0];
    assign raw_y = in_data[COORD_W+COORD_BITS-1:COORD_W];

    always_comb
    begin
        hold_next   = hold_reg;
        // only the low coordinate bits count, sign-extended
        hold_next.x = COORD_W'(raw_x);
        hold_next.y = COORD_W'(raw_y);
        case (in_mode)
            MODE_CLEAR:  hold_next.kind = KIND_CLEAR;
            MODE_APPEND: hold_next.kind = KIND_APPEND;
            MODE_TEST:   hold_next.kind = KIND_TEST;
            default:     hold_next.kind = KIND_NOP;
        endcase
        hold_valid_next = accept ? 1'b1 : (cmd_ready ? 1'b0 : hold_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= hold_next;
        end
    end

endmodule

[rtl/ppt_back.sv]
module ppt_back #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    input  ppt_pkg::cmd_t cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          out_inside,
    output logic          out_full
);

    import ppt_pkg::*;

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int DW   = COORD_BITS + 1;
    localparam int PRW  = 2 * DW;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CNTW-1:0] rd_k_reg, rd_k_next;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic            inside_reg, inside_next;

    logic            out_valid_reg, out_inside_reg, out_full_reg;
    logic            res_load, res_inside, res_full, out_free;

    logic            ram_we;
    logic [AW-1:0]   raddr;
    logic [COORD_BITS-1:0] rd_x, rd_y;

    // edge pipeline: read, differences, products, compare
    logic            s0_vld_reg, s0_first_reg;
    logic            s1_vld_reg, s1_straddle_reg;
    logic signed [DW-1:0]  s1_dy_reg, s1_dx_reg, s1_rx_reg, s1_ry_reg;
    logic            s2_vld_reg, s2_straddle_reg, s2_dypos_reg;
    logic signed [PRW-1:0] s2_p_reg, s2_q_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic            straddle, right;

    assign out_free = !out_valid_reg || out_ready;
    assign cmd_pop  = cmd_valid && (state_reg == S_IDLE)
                      && ((cmd.kind == KIND_TEST) || out_free);
    assign ram_we   = cmd_pop && (cmd.kind == KIND_APPEND) && (cnt_reg < CNTW'(MAX_VERTICES));
    // the last read wraps back to vertex 0 to close the polygon
    assign raddr    = (rd_k_reg == cnt_reg) ? '0 : rd_k_reg[AW-1:0];

    ppt_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_vertex_x_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (cmd.x[COORD_BITS-1:0]),
        .raddr (raddr),
        .rdata (rd_x)
    );

    ppt_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_vertex_y_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (cmd.y[COORD_BITS-1:0]),
        .raddr (raddr),
        .rdata (rd_y)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rd_k_next   = rd_k_reg;
        inside_next = inside_reg;
        res_load    = 1'b0;
        res_inside  = 1'b0;
        res_full    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop)
                begin
                    case (cmd.kind)
                        KIND_CLEAR:
                        begin
                            cnt_next = '0;
                            res_load = 1'b1;
                        end
                        KIND_APPEND:
                        begin
                            res_load = 1'b1;
                            if (ram_we)
                            begin
                                cnt_next = cnt_reg + CNTW'(1);
                            end
                            else
                            begin
                                res_full = 1'b1;
                            end
                        end
                        KIND_TEST:
                        begin
                            inside_next = 1'b0;
                            rd_k_next   = '0;
                            state_next  = (cnt_reg == '0) ? S_DONE : S_WALK;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                rd_k_next = rd_k_reg + CNTW'(1);
                if (rd_k_reg == cnt_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!s0_vld_reg && !s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    res_inside = inside_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (s2_vld_reg && s2_straddle_reg && right)
        begin
            inside_next = !inside_reg;
        end
    end

    assign cur_x    = rd_x;
    assign cur_y    = rd_y;
    // half-open span: one end at or above the query y, the other below
    assign straddle = ((prev_y_reg >= py_reg) && (cur_y < py_reg))
                      || ((prev_y_reg < py_reg) && (cur_y >= py_reg));
    assign right    = s2_dypos_reg ? (s2_p_reg < s2_q_reg) : (s2_p_reg > s2_q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_k_reg      <= '0;
            inside_reg    <= 1'b0;
            s0_vld_reg    <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_k_reg      <= rd_k_next;
            inside_reg    <= inside_next;
            s0_vld_reg    <= (state_reg == S_WALK);
            s1_vld_reg    <= s0_vld_reg && !s0_first_reg;
            s2_vld_reg    <= s1_vld_reg;
            out_valid_reg <= res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && (cmd.kind == KIND_TEST))
        begin
            px_reg <= cmd.x[COORD_BITS-1:0];
            py_reg <= cmd.y[COORD_BITS-1:0];
        end
        s0_first_reg <= (rd_k_reg == '0);
        if (s0_vld_reg)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        s1_straddle_reg <= straddle;
        s1_dy_reg <= {cur_y[COORD_BITS-1], cur_y} - {prev_y_reg[COORD_BITS-1], prev_y_reg};
        s1_dx_reg <= {cur_x[COORD_BITS-1], cur_x} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
        s1_rx_reg <= {px_reg[COORD_BITS-1], px_reg} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
        s1_ry_reg <= {py_reg[COORD_BITS-1], py_reg} - {prev_y_reg[COORD_BITS-1], prev_y_reg};
        s2_straddle_reg <= s1_straddle_reg;
        s2_dypos_reg    <= !s1_dy_reg[DW-1] && (s1_dy_reg != '0);
        s2_p_reg        <= s1_rx_reg * s1_dy_reg;
        s2_q_reg        <= s1_dx_reg * s1_ry_reg;
        if (res_load)
        begin
            out_inside_reg <= res_inside;
            out_full_reg   <= res_full;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_inside = out_inside_reg;
    assign out_full   = out_full_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !ram_we)
        else $error("vertex store written during a test");

    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !(s0_vld_reg || s1_vld_reg || s2_vld_reg))
        else $error("test result taken before edge pipeline drained");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (rd_k_reg <= cnt_reg))
        else $error("edge walk ran past the closing edge");

endmodule

[rtl/point_in_polygon_test.sv]
// append, clear and unused-mode transactions: result registered through the hold register,
//   command queue and output register; one per cycle sustained unless the output stalls
// test: the back end walks the edges with vertex_count + 1 reads (none with no vertices),
//   drains the edge pipeline and takes no new command until the result is loaded
// a two-entry command queue lets input accepts continue while a test walks
// reset: asynchronous, active low; clears vertex count, queue and handshakes
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // coord_x [31:0], coord_y [63:32]
    input  logic [1:0]  s_axis_tuser,   // mode [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // inside_res [0], store_full [1], zero [7:2]
);

    import ppt_pkg::*;

    cmd_t front_cmd, queue_cmd;
    logic front_valid, queue_full, queue_not_empty, queue_pop;
    logic res_inside, res_full;

    ppt_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cmd_valid (front_valid),
        .cmd_ready (!queue_full),
        .cmd       (front_cmd)
    );

    ppt_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .din       (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .dout      (queue_cmd),
        .not_empty (queue_not_empty)
    );

    ppt_back #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (queue_not_empty),
        .cmd_pop    (queue_pop),
        .cmd        (queue_cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_inside (res_inside),
        .out_full   (res_full)
    );

    assign m_axis_tdata = {6'b0, res_full, res_inside};

endmodule
